// ===== rtl/box_fan_region_clear_test_defines.svh =====
// Assertion macros for the box fan region clear test.
// Uses clk_i and rst_ni of the including module; no other dependencies.
`ifndef BOX_FAN_REGION_CLEAR_TEST_DEFINES_SVH
`define BOX_FAN_REGION_CLEAR_TEST_DEFINES_SVH
`ifndef SYNTH
`define BFRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BFRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define BFRC_ASSERT(lbl, prop, msg)
`define BFRC_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/bfrc_pkg.sv =====
// Shared constants for the box fan region clear test.
// No dependencies.
package bfrc_pkg;
  localparam int COORD_WIDTH_DEF = 24;
  localparam int NUM_CORNERS     = 4;
  localparam int LATENCY         = 6;

  // Corner order: 0 (max_x,min_y), 1 (max_x,max_y), 2 (min_x,max_y), 3 (min_x,min_y).
  // Select 0 picks the max x, select 1 the min x.
  function automatic logic corner_xsel(input int c);
    return (c >= 2);
  endfunction

  // Select 0 picks the min y, select 1 the max y.
  function automatic logic corner_ysel(input int c);
    return (c == 1) || (c == 2);
  endfunction
endpackage

// ===== rtl/box_fan_region_clear_test.sv =====
// Top level of the box fan region clear test: a six stage pipeline.
// Depends on bfrc_pkg and box_fan_region_clear_test_defines.svh.
//
// Usage: drive the box and the two dividers and raise start; a transaction
// is taken at each rising edge with start high and busy low. busy stays low,
// so one transaction may enter in every cycle. When it leaves stage 6,
// valid_o is high for exactly one cycle with region_clear_o and
// edge_hit_mask_o; results come out in acceptance order, one per cycle at
// full rate. The latency is set by the pipeline: offsets, side products,
// side values, split cross products, their sum, and the final decision.
// The cross product of side values is too wide for one multiplier and is
// cut into four partial products per term, summed in the following stage.
// There is no state between transactions. Reset clears only the valid bits
// of the stages, so nothing is reported until a new transaction passes.
// The receiver cannot stall; each result must be taken in its cycle.
`include "box_fan_region_clear_test_defines.svh"
module box_fan_region_clear_test
  import bfrc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] box_min_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_y_i,
  input  logic signed [COORD_WIDTH-1:0] prev_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] prev_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] prev_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] prev_end_y_i,
  input  logic signed [COORD_WIDTH-1:0] cur_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] cur_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] cur_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] cur_end_y_i,
  output logic                          valid_o,
  output logic                          region_clear_o,
  output logic [NUM_CORNERS-1:0]        edge_hit_mask_o
);
  localparam int DW = COORD_WIDTH + 1;   // coordinate differences
  localparam int PW = 2 * DW;            // side products
  localparam int SW = PW + 1;            // side values
  localparam int HW = (SW + 1) / 2;      // low split, unsigned
  localparam int LW = SW - HW;           // high split, signed
  localparam int MW = 2 * SW + 1;        // cross product difference

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 1: divider directions and corner offsets. Index 0 is prev, 1 is cur.
  logic                 v1_q;
  logic signed [DW-1:0] dx1_q [2];
  logic signed [DW-1:0] dy1_q [2];
  logic signed [DW-1:0] ox1_q [2][2];
  logic signed [DW-1:0] oy1_q [2][2];

  logic signed [COORD_WIDTH-1:0] sx_in [2];
  logic signed [COORD_WIDTH-1:0] sy_in [2];
  logic signed [COORD_WIDTH-1:0] ex_in [2];
  logic signed [COORD_WIDTH-1:0] ey_in [2];
  assign sx_in[0] = prev_start_x_i;
  assign sy_in[0] = prev_start_y_i;
  assign ex_in[0] = prev_end_x_i;
  assign ey_in[0] = prev_end_y_i;
  assign sx_in[1] = cur_start_x_i;
  assign sy_in[1] = cur_start_y_i;
  assign ex_in[1] = cur_end_x_i;
  assign ey_in[1] = cur_end_y_i;

  always_ff @(posedge clk_i) begin
    for (int d = 0; d < 2; d++) begin
      dx1_q[d]    <= DW'(ex_in[d]) - DW'(sx_in[d]);
      dy1_q[d]    <= DW'(ey_in[d]) - DW'(sy_in[d]);
      ox1_q[d][0] <= DW'(box_max_x_i) - DW'(sx_in[d]);
      ox1_q[d][1] <= DW'(box_min_x_i) - DW'(sx_in[d]);
      oy1_q[d][0] <= DW'(box_min_y_i) - DW'(sy_in[d]);
      oy1_q[d][1] <= DW'(box_max_y_i) - DW'(sy_in[d]);
    end
  end

  // Stage 2: side products dx*(py-sy) and dy*(px-sx).
  logic                 v2_q;
  logic signed [PW-1:0] my2_q [2][2];
  logic signed [PW-1:0] mx2_q [2][2];

  always_ff @(posedge clk_i) begin
    for (int d = 0; d < 2; d++) begin
      for (int k = 0; k < 2; k++) begin
        my2_q[d][k] <= dx1_q[d] * oy1_q[d][k];
        mx2_q[d][k] <= dy1_q[d] * ox1_q[d][k];
      end
    end
  end

  // Stage 3: side value of every corner against both dividers; positive is left.
  logic                 v3_q;
  logic signed [SW-1:0] side3_q [2][NUM_CORNERS];

  always_ff @(posedge clk_i) begin
    for (int d = 0; d < 2; d++) begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
        side3_q[d][c] <= SW'(my2_q[d][corner_ysel(c)]) - SW'(mx2_q[d][corner_xsel(c)]);
      end
    end
  end

  // Stage 4: partial products of a_i*c_n and a_n*c_i per edge, plus sign and zero flags.
  logic                      v4_q;
  logic signed [2*LW-1:0]    hh4_q [2][NUM_CORNERS];
  logic signed [LW+HW:0]     hl4_q [2][NUM_CORNERS];
  logic signed [LW+HW:0]     lh4_q [2][NUM_CORNERS];
  logic        [2*HW-1:0]    ll4_q [2][NUM_CORNERS];
  logic [NUM_CORNERS-1:0]    aneg4_q, cneg4_q, czero4_q;

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < NUM_CORNERS; e++) begin
      for (int t = 0; t < 2; t++) begin
        // Term 0 is a_i*c_n, term 1 is a_n*c_i.
        logic signed [SW-1:0] a, c;
        a = side3_q[0][(t == 0) ? e : ((e + 1) % NUM_CORNERS)];
        c = side3_q[1][(t == 0) ? ((e + 1) % NUM_CORNERS) : e];
        hh4_q[t][e] <= $signed(a[SW-1:HW]) * $signed(c[SW-1:HW]);
        hl4_q[t][e] <= $signed(a[SW-1:HW]) * $signed({1'b0, c[HW-1:0]});
        lh4_q[t][e] <= $signed({1'b0, a[HW-1:0]}) * $signed(c[SW-1:HW]);
        ll4_q[t][e] <= a[HW-1:0] * c[HW-1:0];
      end
      aneg4_q[e]  <= side3_q[0][e][SW-1];
      cneg4_q[e]  <= side3_q[1][e][SW-1];
      czero4_q[e] <= (side3_q[1][e] == '0);
    end
  end

  // Stage 5: assemble both terms and take the sign and zero flag of a_i*c_n - a_n*c_i.
  logic                   v5_q;
  logic [NUM_CORNERS-1:0] mneg5_q, mzero5_q;
  logic [NUM_CORNERS-1:0] aneg5_q, cneg5_q, czero5_q;
  logic signed [MW-1:0]   term [2][NUM_CORNERS];
  logic signed [MW-1:0]   mdiff [NUM_CORNERS];

  always_comb begin
    for (int e = 0; e < NUM_CORNERS; e++) begin
      for (int t = 0; t < 2; t++) begin
        logic signed [MW-1:0] p_hh, p_hl, p_lh, p_ll;
        p_hh = MW'(hh4_q[t][e]);
        p_hl = MW'(hl4_q[t][e]);
        p_lh = MW'(lh4_q[t][e]);
        p_ll = $signed(MW'(ll4_q[t][e]));
        term[t][e] = (p_hh <<< (2 * HW)) + ((p_hl + p_lh) <<< HW) + p_ll;
      end
      mdiff[e] = term[0][e] - term[1][e];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < NUM_CORNERS; e++) begin
      mneg5_q[e]  <= mdiff[e][MW-1];
      mzero5_q[e] <= (mdiff[e] == '0);
    end
    aneg5_q  <= aneg4_q;
    cneg5_q  <= cneg4_q;
    czero5_q <= czero4_q;
  end

  // Stage 6: an edge hits when some point of it is left of prev and right of cur.
  // Either one end point satisfies both, or the feasible part lies strictly
  // inside and the crossing of one divider is on the good side of the other.
  logic                   v6_q;
  logic [NUM_CORNERS-1:0] mask6_q;
  logic [NUM_CORNERS-1:0] hit;

  always_comb begin
    for (int e = 0; e < NUM_CORNERS; e++) begin
      logic a0n, a1n, c0le, c1le, c0pos, c1pos;
      a0n   = aneg5_q[e];
      a1n   = aneg5_q[(e + 1) % NUM_CORNERS];
      c0le  = cneg5_q[e] || czero5_q[e];
      c1le  = cneg5_q[(e + 1) % NUM_CORNERS] || czero5_q[(e + 1) % NUM_CORNERS];
      c0pos = !c0le;
      c1pos = !c1le;
      hit[e] = (!a0n && c0le) || (!a1n && c1le)
            || (a0n && !a1n && c0le && c1pos && !mneg5_q[e])
            || (!a0n && a1n && c0pos && c1le && (mneg5_q[e] || mzero5_q[e]));
    end
  end

  always_ff @(posedge clk_i) begin
    mask6_q <= hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  assign valid_o         = v6_q;
  assign edge_hit_mask_o = mask6_q;
  assign region_clear_o  = (mask6_q == '0);

  `BFRC_ASSERT_IMP(a_latency, accept, ##6 valid_o, "transaction result is late")
  `BFRC_ASSERT_IMP(a_no_extra, valid_o, $past(accept, LATENCY), "result without a transaction")
  `BFRC_ASSERT(a_clear_mask, region_clear_o == (edge_hit_mask_o == '0), "bad clear flag")
endmodule
